/* hw/rtl/conv3x3_valid_stream_assert.svh */
// Assertion macros used by the RTL of the 3x3 convolution stream.
`ifndef CONV3X3_VALID_STREAM_ASSERT_SVH
`define CONV3X3_VALID_STREAM_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CV3_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("cv3 assertion failed");

`define CV3_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("cv3 assertion failed");

`else

`define CV3_ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define CV3_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

/* hw/rtl/cv3_pkg.sv */
package cv3_pkg;

   localparam int PIXEL_W           = 16;
   localparam int KERNEL_ROW_W      = 48;
   localparam int FRAME_WIDTH_W     = 11;
   localparam int FRAME_HEIGHT_W    = 16;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 48;
   localparam int WINDOW_DIM        = 3;
   localparam int WINDOW_TAPS       = WINDOW_DIM * WINDOW_DIM;
   localparam int CMP_W             = 17;
   localparam int DEFAULT_MAX_WIDTH = 1024;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd480;
   localparam logic [KERNEL_ROW_W-1:0]   KERNEL_TOP_RESET   = 48'd0;
   localparam logic [KERNEL_ROW_W-1:0]   KERNEL_MID_RESET   = 48'd65536;
   localparam logic [KERNEL_ROW_W-1:0]   KERNEL_BOT_RESET   = 48'd0;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 3'd0,
      CSR_FRAME_HEIGHT  = 3'd1,
      CSR_KERNEL_TOP    = 3'd2,
      CSR_KERNEL_MIDDLE = 3'd3,
      CSR_KERNEL_BOTTOM = 3'd4
   } csr_index_type;

endpackage

/* hw/rtl/cv3_ram.sv */
module cv3_ram import cv3_pkg::*; #(
   parameter int WIDTH = PIXEL_W,
   parameter int DEPTH = DEFAULT_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/conv3x3_valid_stream.sv */
// Streaming 3x3 convolution over the valid region of a frame of signed 16-bit pixels sent
// in raster order. It takes one pixel word per clock unless the output stalls; the input,
// product and output stages register one result word for every window centred on an
// interior pixel; rsp_tlast marks the frame's last result. The rate is set by the two
// line store RAMs, each read once when a pixel is accepted and written once when that
// pixel leaves the input stage; the nine multipliers and the adder tree are pipelined
// behind them. The line stores are not cleared after reset; a result only uses entries
// written earlier in the same frame, unless the width grows in the middle of a frame.
// Registers may only be written while no word is in flight.
`include "conv3x3_valid_stream_assert.svh"

module conv3x3_valid_stream import cv3_pkg::*; #(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIXEL_W-1:0]     req_tdata,   // pixel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIXEL_W-1:0]     rsp_tdata,   // filtered
   output logic                   rsp_tlast,   // frame_end
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [KERNEL_ROW_W-1:0]   kernel_ff [WINDOW_DIM];

   logic [COL_W-1:0]          column_count_ff, column_count_in;
   logic [FRAME_HEIGHT_W-1:0] row_count_ff, row_count_in;
   logic [CMP_W-1:0]          width_eff, height_eff;
   logic                      last_col, last_row, produce, accept;

   logic                      s1_valid_ff, s1_valid_in;
   pixel_type                 s1_pixel_ff;
   logic [COL_W-1:0]          s1_col_ff;
   logic                      s1_produce_ff;
   logic                      s1_end_ff;
   logic                      s1_move;

   pixel_type                 top_data, mid_data;
   pixel_type                 window_ff [WINDOW_TAPS];
   pixel_type                 window_in [WINDOW_TAPS];

   logic                      s2_valid_ff, s2_valid_in;
   pixel_type                 s2_prod_ff [WINDOW_TAPS];
   pixel_type                 s2_prod_in [WINDOW_TAPS];
   logic                      s2_end_ff;
   logic                      s2_free;

   logic                      rsp_valid_ff, rsp_valid_in;
   pixel_type                 rsp_data_ff, rsp_data_in;
   logic                      rsp_last_ff;
   logic                      out_free;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         kernel_ff[0]    <= KERNEL_TOP_RESET;
         kernel_ff[1]    <= KERNEL_MID_RESET;
         kernel_ff[2]    <= KERNEL_BOT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_ff  <= csr_data[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff <= csr_data[FRAME_HEIGHT_W-1:0];
            CSR_KERNEL_TOP:    kernel_ff[0]    <= csr_data[KERNEL_ROW_W-1:0];
            CSR_KERNEL_MIDDLE: kernel_ff[1]    <= csr_data[KERNEL_ROW_W-1:0];
            CSR_KERNEL_BOTTOM: kernel_ff[2]    <= csr_data[KERNEL_ROW_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake chain through the three stages.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_move    = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s2_free;
   assign accept     = req_tvalid && req_tready;

   // Frame position of the incoming pixel.
   always_comb begin
      if (CMP_W'(frame_width_ff) > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else if (frame_width_ff == '0) begin
         width_eff = CMP_W'(1);
      end else begin
         width_eff = CMP_W'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = CMP_W'(1);
      end else begin
         height_eff = CMP_W'(frame_height_ff);
      end
      last_col = (CMP_W'(column_count_ff) + CMP_W'(1)) >= width_eff;
      last_row = (CMP_W'(row_count_ff) + CMP_W'(1)) >= height_eff;
      produce  = (CMP_W'(row_count_ff) >= CMP_W'(WINDOW_DIM - 1))
              && (CMP_W'(column_count_ff) >= CMP_W'(WINDOW_DIM - 1));

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (last_col) begin
            column_count_in = '0;
            row_count_in    = last_row ? '0 : row_count_ff + FRAME_HEIGHT_W'(1);
         end else begin
            column_count_in = column_count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // Input stage: the line stores are read as the pixel is accepted.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_pixel_ff   <= req_tdata;
         s1_col_ff     <= column_count_ff;
         s1_produce_ff <= produce;
         s1_end_ff     <= last_col && last_row;
      end
   end

   cv3_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (mid_data),
      .rd_en   (accept),
      .rd_addr (column_count_ff),
      .rd_data (top_data)
   );

   cv3_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_lower (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (accept),
      .rd_addr (column_count_ff),
      .rd_data (mid_data)
   );

   // Window shift and the nine products, truncated to 16 bits.
   always_comb begin
      logic [2*PIXEL_W-1:0] full_prod;
      for (int r = 0; r < WINDOW_DIM; r++) begin
         for (int c = 0; c < WINDOW_DIM - 1; c++) begin
            window_in[r*WINDOW_DIM+c] = window_ff[r*WINDOW_DIM+c+1];
         end
      end
      window_in[WINDOW_DIM-1]             = top_data;
      window_in[2*WINDOW_DIM-1]           = mid_data;
      window_in[WINDOW_DIM*WINDOW_DIM-1]  = s1_pixel_ff;
      for (int i = 0; i < WINDOW_TAPS; i++) begin
         full_prod = window_in[i]
                   * kernel_ff[i / WINDOW_DIM][(i % WINDOW_DIM)*PIXEL_W +: PIXEL_W];
         s2_prod_in[i] = full_prod[PIXEL_W-1:0];
      end
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         s2_valid_in = s1_produce_ff;
      end else if (out_free) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW_TAPS; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         s2_valid_ff <= s2_valid_in;
         if (s1_move) begin
            for (int i = 0; i < WINDOW_TAPS; i++) begin
               window_ff[i] <= window_in[i];
            end
         end
      end
      if (s1_move) begin
         for (int i = 0; i < WINDOW_TAPS; i++) begin
            s2_prod_ff[i] <= s2_prod_in[i];
         end
         s2_end_ff <= s1_end_ff;
      end
   end

   // Output stage: sum of the products, wrapping at 16 bits.
   always_comb begin
      rsp_data_in = '0;
      for (int i = 0; i < WINDOW_TAPS; i++) begin
         rsp_data_in = rsp_data_in + s2_prod_ff[i];
      end
      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_free && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= s2_end_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CV3_ASSERT_IMPLIES(a_col_range, clock, reset, 1'b1, CMP_W'(column_count_ff) < CMP_W'(MAX_WIDTH))
   `CV3_ASSERT_NEXT(a_s2_hold, clock, reset, s2_valid_ff && !out_free, s2_valid_ff)
   `CV3_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s2_free, s1_valid_ff && $stable(s1_col_ff))

endmodule
